@@ sv/lsh_pkg.sv @@
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants of the Laplacian sharpen block
// Widths of the pixel stream, the line store, the emission counters and the
// position divider, plus the helpers that clamp the frame size registers.
// ----------------------------------------------------------------------------
package lsh_pkg;

    // Largest frame width, and the depth of each line store.
    localparam int MAX_WIDTH = 2048;

    localparam int PIX_W    = 8;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int CFG_W    = 12;
    localparam int IDX_W    = 23;
    localparam int EROW_W   = 22;
    localparam int LS_AW    = $clog2(MAX_WIDTH);
    localparam int LS_DW    = 2 * PIX_W;
    localparam int CFG_IDX_W = 1;

    // Frame size limits applied to the register values.
    localparam logic [CFG_W-1:0] MIN_DIM   = CFG_W'(3);
    localparam logic [CFG_W-1:0] MAX_W_EFF = CFG_W'(MAX_WIDTH);

    // Position divider: one quotient bit per cycle.
    localparam int DIV_STEPS = IDX_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Position divider states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    // Status of the position divider as seen by the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // One request held between the input and the result register.
    typedef struct packed {
        logic             valid;
        logic             load;
        logic             emit;
        logic             interior;
        logic             last;
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] pcol;
    } t_s1;

    // Frame width as used by the datapath: at least 3, at most MAX_WIDTH.
    function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end else if (v > MAX_W_EFF) begin
            r = MAX_W_EFF;
        end
        return r;
    endfunction

    // Frame height as used by the datapath: at least 3.
    function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end
        return r;
    endfunction

endpackage

@@ sv/lsh_ram.sv @@
// ----------------------------------------------------------------------------
// lsh_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/lsh_div.sv @@
// ----------------------------------------------------------------------------
// lsh_div: bit-serial position divider
// Splits the linear emission index into row and column for a new frame
// width, one quotient bit per cycle with a restoring step.
// ----------------------------------------------------------------------------
module lsh_div import lsh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IDX_W-1:0]  i_dividend,
    input  logic [CFG_W-1:0]  i_divisor,
    output t_div_stat         o_stat,
    output logic [EROW_W-1:0] o_quot,
    output logic [COL_W-1:0]  o_rem
);

    t_div_state           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]     r_q;
    logic [CFG_W-1:0]     r_rem;
    logic [CFG_W-1:0]     r_div;
    logic [CFG_W-1:0]     rem_sh;
    logic                 fits;

    // Next state: a new start always restarts the division.
    always_comb begin
        n_state = r_state;
        priority if (i_start) begin
            n_state = DIV_RUN;
        end else begin
            unique case (r_state)
                DIV_IDLE: n_state = DIV_IDLE;
                DIV_RUN:  n_state = (r_cnt == '0) ? DIV_DONE : DIV_RUN;
                DIV_DONE: n_state = DIV_IDLE;
                default:  n_state = DIV_IDLE;
            endcase
        end
    end

    // Status outputs.
    always_comb begin
        o_stat = '0;
        unique case (r_state)
            DIV_IDLE: o_stat = '0;
            DIV_RUN:  o_stat.busy = 1'b1;
            DIV_DONE: begin
                o_stat.busy = 1'b1;
                o_stat.done = 1'b1;
            end
            default:  o_stat = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_state == DIV_RUN) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    // Restoring step: the remainder stays below the divisor, so it fits.
    assign rem_sh = {r_rem[CFG_W-2:0], r_q[IDX_W-1]};
    assign fits   = (rem_sh >= r_div);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_state == DIV_RUN) begin
            r_q   <= {r_q[IDX_W-2:0], fits};
            r_rem <= fits ? (rem_sh - r_div) : rem_sh;
        end
    end

    assign o_quot = r_q[EROW_W-1:0];
    assign o_rem  = r_rem[COL_W-1:0];

endmodule

@@ sv/lsh_sharpen.sv @@
// ----------------------------------------------------------------------------
// lsh_sharpen: neighborhood window and cross-kernel arithmetic
// Holds the window columns that the kernel still needs, forms the line store
// write data and computes the saturated sharpen value of the window centre.
// ----------------------------------------------------------------------------
module lsh_sharpen import lsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [PIX_W-1:0] i_px,
    input  logic [LS_DW-1:0] i_rd_data,
    output logic [LS_DW-1:0] o_wr_data,
    output logic [PIX_W-1:0] o_value
);

    // Right column of the top row, two right columns of the middle row and
    // the right column of the bottom row, as left by the previous load.
    logic [PIX_W-1:0] r_top_c2;
    logic [PIX_W-1:0] r_mid_c1;
    logic [PIX_W-1:0] r_mid_c2;
    logic [PIX_W-1:0] r_bot_c2;
    logic [PIX_W-1:0] top_new;
    logic [PIX_W-1:0] mid_new;
    logic [PIX_W+2:0] centre_x5;
    logic signed [PIX_W+3:0] acc;

    assign top_new = i_rd_data[LS_DW-1:PIX_W];
    assign mid_new = i_rd_data[PIX_W-1:0];

    // The middle row moves up one line, the new pixel takes its place.
    assign o_wr_data = {mid_new, i_px};

    // After the shift the centre is the old middle right column.
    assign centre_x5 = {1'b0, r_mid_c2, 2'b00} + {3'b000, r_mid_c2};
    assign acc = signed'({1'b0, centre_x5})
               - signed'({4'b0000, r_mid_c1})
               - signed'({4'b0000, mid_new})
               - signed'({4'b0000, r_top_c2})
               - signed'({4'b0000, r_bot_c2});

    // Saturate to the pixel range.
    always_comb begin
        if (acc[PIX_W+3]) begin
            o_value = '0;
        end else if (acc[PIX_W+2:PIX_W] != '0) begin
            o_value = '1;
        end else begin
            o_value = acc[PIX_W-1:0];
        end
    end

    // Window shift on every pixel load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_c2 <= '0;
            r_mid_c1 <= '0;
            r_mid_c2 <= '0;
            r_bot_c2 <= '0;
        end else if (i_load) begin
            r_top_c2 <= top_new;
            r_mid_c1 <= r_mid_c2;
            r_mid_c2 <= mid_new;
            r_bot_c2 <= i_px;
        end
    end

endmodule

@@ sv/laplacian_sharpen_3x3.sv @@
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3: streaming 3x3 cross-kernel sharpen
// Top level: frame counters, request pipeline, line store and result register.
// ----------------------------------------------------------------------------
// The block takes one request per clock while o_in_stall is low: grayscale
// pixels of a frame in raster order, then frame_width+1 flush requests. From
// the request with index frame_width+1 on, each request gives the result for
// the raster position frame_width+1 places earlier; border pixels give 0. A
// result passes from the input through the middle stage register to the output
// register, and a waiting result still lets one more request enter before the
// input stalls. Each pixel accepted while filling makes one read and one write
// of the combined line store. After a write of frame_width the input stalls
// while a one-bit-per-cycle divider recomputes the row and column of the next
// result for the new width.
module laplacian_sharpen_3x3 import lsh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel_value,
    input  logic                 i_flush,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [COL_W-1:0]     o_out_col,
    output logic [PIX_W-1:0]     o_out_value,
    output logic                 o_end_of_frame,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic              r_loaded, n_loaded;
    logic [IDX_W-1:0]  r_emit_index, n_emit_index;
    logic [EROW_W-1:0] r_emit_row, n_emit_row;
    logic [COL_W-1:0]  r_emit_col, n_emit_col;
    t_s1               r_s1, n_s1;
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [PIX_W-1:0]  r_out_value;
    logic              r_out_last;

    logic [CFG_W-1:0]  w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic              cfg_w_wr;
    logic              s1_adv;
    logic              s1_free;
    logic              in_fire;
    logic              emit_pos;
    logic              interior_pos;
    logic              last_pos;
    logic              in_col_wrap;
    logic              in_row_wrap;
    logic              emit_col_wrap;
    logic              ram_we;
    logic [LS_DW-1:0]  ram_rdata;
    logic [LS_DW-1:0]  ram_wdata;
    logic [PIX_W-1:0]  sharp_value;
    t_div_stat         div_stat;
    logic [EROW_W-1:0] div_quot;
    logic [COL_W-1:0]  div_rem;

    assign w_eff = eff_width(r_frame_width);
    assign h_eff = eff_height(r_frame_height);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    assign cfg_w_wr = i_cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_FRAME_WIDTH);

    // Recompute the next result position whenever the width register is written.
    lsh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cfg_w_wr),
        .i_dividend (r_emit_index),
        .i_divisor  (eff_width(i_cfg_data)),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Handshake: the middle stage moves on when the result register is free
    // or is being taken.
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1.valid || s1_adv;
    assign o_in_stall = !s1_free || cfg_w_wr || div_stat.busy;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Position decisions for the request at the input.
    assign emit_pos = (r_in_row >= ROW_W'(2))
                   || ((r_in_row == ROW_W'(1)) && (r_in_col != '0))
                   || ((r_in_row == '0) && ({1'b0, r_in_col} >= (w_eff + CFG_W'(1))));

    assign interior_pos = (r_emit_row != '0)
                       && ((r_emit_row + EROW_W'(1)) < EROW_W'(h_eff))
                       && (r_emit_col != '0)
                       && (({1'b0, r_emit_col} + CFG_W'(1)) < w_eff);

    assign emit_col_wrap = ({1'b0, r_emit_col} + CFG_W'(1)) >= w_eff;

    assign last_pos = (r_emit_row >= EROW_W'(h_eff))
                   || (((r_emit_row + EROW_W'(1)) == EROW_W'(h_eff)) && emit_col_wrap);

    assign in_col_wrap = ({1'b0, r_in_col} + CFG_W'(1)) >= w_eff;
    assign in_row_wrap = ({1'b0, r_in_row} + (ROW_W+1)'(1)) >= {1'b0, h_eff};

    // Counters and the middle stage.
    always_comb begin
        n_in_row     = r_in_row;
        n_in_col     = r_in_col;
        n_loaded     = r_loaded;
        n_emit_index = r_emit_index;
        n_emit_row   = r_emit_row;
        n_emit_col   = r_emit_col;
        n_s1         = r_s1;
        if (s1_adv) begin
            n_s1.valid = 1'b0;
        end
        if (in_fire) begin
            n_s1.px   = i_pixel_value;
            n_s1.col  = r_in_col;
            n_s1.row  = r_emit_row[ROW_W-1:0];
            n_s1.pcol = r_emit_col;
            if (!r_loaded) begin
                // Filling: a pixel loads the window, a flush is dropped.
                if (!i_flush) begin
                    n_s1.valid    = 1'b1;
                    n_s1.load     = 1'b1;
                    n_s1.emit     = emit_pos;
                    n_s1.interior = emit_pos && interior_pos;
                    n_s1.last     = 1'b0;
                    if (in_col_wrap) begin
                        n_in_col = '0;
                        if (in_row_wrap) begin
                            n_in_row = '0;
                            n_loaded = 1'b1;
                        end else begin
                            n_in_row = r_in_row + ROW_W'(1);
                        end
                    end else begin
                        n_in_col = r_in_col + COL_W'(1);
                    end
                    if (emit_pos) begin
                        n_emit_index = r_emit_index + IDX_W'(1);
                        if (emit_col_wrap) begin
                            n_emit_col = '0;
                            n_emit_row = r_emit_row + EROW_W'(1);
                        end else begin
                            n_emit_col = r_emit_col + COL_W'(1);
                        end
                    end
                end
            end else begin
                // Draining: every request gives a border result.
                n_s1.valid    = 1'b1;
                n_s1.load     = 1'b0;
                n_s1.emit     = 1'b1;
                n_s1.interior = 1'b0;
                n_s1.last     = last_pos;
                if (last_pos) begin
                    n_emit_index = '0;
                    n_emit_row   = '0;
                    n_emit_col   = '0;
                    n_loaded     = 1'b0;
                    n_in_row     = '0;
                    n_in_col     = '0;
                end else begin
                    n_emit_index = r_emit_index + IDX_W'(1);
                    if (emit_col_wrap) begin
                        n_emit_col = '0;
                        n_emit_row = r_emit_row + EROW_W'(1);
                    end else begin
                        n_emit_col = r_emit_col + COL_W'(1);
                    end
                end
            end
        end
        if (div_stat.done) begin
            n_emit_row = div_quot;
            n_emit_col = div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_loaded     <= 1'b0;
            r_emit_index <= '0;
            r_emit_row   <= '0;
            r_emit_col   <= '0;
            r_s1         <= '0;
        end else begin
            r_in_row     <= n_in_row;
            r_in_col     <= n_in_col;
            r_loaded     <= n_loaded;
            r_emit_index <= n_emit_index;
            r_emit_row   <= n_emit_row;
            r_emit_col   <= n_emit_col;
            r_s1         <= n_s1;
        end
    end

    // Both line stores share one RAM: upper byte is the older row.
    assign ram_we = r_s1.valid && r_s1.load && s1_adv;

    lsh_ram #(
        .WIDTH (LS_DW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.col),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    lsh_sharpen u_sharpen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (ram_we),
        .i_px      (r_s1.px),
        .i_rd_data (ram_rdata),
        .o_wr_data (ram_wdata),
        .o_value   (sharp_value)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1.valid && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.valid && r_s1.emit) begin
            r_out_row   <= r_s1.row;
            r_out_col   <= r_s1.pcol;
            r_out_value <= r_s1.interior ? sharp_value : '0;
            r_out_last  <= r_s1.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_out_value    = r_out_value;
    assign o_end_of_frame = r_out_last;

`ifndef SYNTH
    // While draining, the input counters sit at the start of the next frame.
    a_loaded_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded |-> ((r_in_row == '0) && (r_in_col == '0)))
        else $error("input counters moved while draining");

    // Outside a recompute the result column stays inside the row.
    a_emit_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !div_stat.busy |-> ({1'b0, r_emit_col} < w_eff))
        else $error("result column outside the frame width");

    // The last result of a frame is a border pixel.
    a_last_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> (o_out_value == '0))
        else $error("end of frame on a nonzero result");

    // A line store read never meets the write of the same column.
    a_ram_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && in_fire) |-> (r_s1.col != r_in_col))
        else $error("line store read and write at the same column");
`endif

endmodule
